// ===== design/pbas_pkg.sv =====
package pbas_pkg;

  // fixed timing constants
  localparam logic [31:0] PumpRearmSec = 32'd1800;
  localparam logic [25:0] MsPerSec     = 26'd1000;

  // 2^33 / 3 rounded up, for an exact floor(x / 3) on 32-bit x
  localparam logic [63:0] ThirdRecip   = 64'h0000_0000_AAAA_AAAB;

  // reset values of the configuration registers and of their derived forms
  localparam logic [31:0] IntervalRst  = 32'd3600;
  localparam logic [31:0] ThirdRst     = 32'd1200;
  localparam logic [25:0] PumpMsRst    = 26'd10000;
  localparam logic [25:0] BlowMsRst    = 26'd60000;
  localparam logic [23:0] HumLowRst    = 24'd0;
  localparam logic signed [15:0] Thr50Rst = 16'sd7000;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL  = 3'd0,
    CFG_PUMP_ON   = 3'd1,
    CFG_BLOWER_ON = 3'd2,
    CFG_HUM_LOW   = 3'd3,
    CFG_TEMP_HI_0 = 3'd4,
    CFG_TEMP_HI_1 = 3'd5,
    CFG_TEMP_HI_2 = 3'd6
  } cfg_idx_e;

  // blower sequence state, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ONE  = 3'b010,
    PH_TWO  = 3'b100
  } phase_e;

  // phase codes as reported on the result
  localparam logic [1:0] PhaseCodeIdle = 2'd0;
  localparam logic [1:0] PhaseCodeOne  = 2'd1;
  localparam logic [1:0] PhaseCodeTwo  = 2'd2;
  localparam logic [1:0] PhaseCodeBad  = 2'd3;

  typedef struct packed {
    logic [31:0]        epoch_sec;
    logic [31:0]        uptime_ms;
    logic [6:0]         humidity_0;
    logic [6:0]         humidity_1;
    logic [6:0]         humidity_2;
    logic signed [11:0] temp_c10_0;
    logic signed [11:0] temp_c10_1;
    logic signed [11:0] temp_c10_2;
  } in_item_t;

  typedef struct packed {
    logic       pump_drive;
    logic       blower1_drive;
    logic       blower2_drive;
    logic [1:0] blower_phase;
    logic       pump_started;
    logic       blower_started;
    logic       hot_start;
  } out_item_t;

  // configuration as the scheduler sees it, products already formed
  typedef struct packed {
    logic [31:0]        interval_sec;
    logic [31:0]        third_sec;
    logic [25:0]        pump_on_ms;
    logic [25:0]        blow_on_ms;
    logic [23:0]        hum_low;
    logic signed [15:0] thr50_0;
    logic signed [15:0] thr50_1;
    logic signed [15:0] thr50_2;
  } cfg_t;

endpackage

// ===== design/pbas_if.sv =====
interface pbas_in_if;
  import pbas_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pbas_out_if;
  import pbas_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pbas_cfg_if;
  import pbas_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== design/pbas_cfg_regs.sv =====
module pbas_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [pbas_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [pbas_pkg::CfgDataW-1:0] wr_data_i,
  output pbas_pkg::cfg_t                cfg_o
);
  import pbas_pkg::*;

  cfg_t cfg_q, cfg_d;

  logic [63:0]        third_prod;
  logic [25:0]        sec_to_ms;
  logic signed [15:0] thr_ext;
  logic signed [15:0] thr50;

  // precompute the products once per write
  assign third_prod = {32'd0, wr_data_i} * ThirdRecip;
  assign sec_to_ms  = {10'd0, wr_data_i[15:0]} * MsPerSec;
  assign thr_ext    = {{6{wr_data_i[9]}}, wr_data_i[9:0]};
  assign thr50      = thr_ext * 16'sd50;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CFG_INTERVAL: begin
          cfg_d.interval_sec = wr_data_i;
          cfg_d.third_sec    = {1'b0, third_prod[63:33]};
        end
        CFG_PUMP_ON:   cfg_d.pump_on_ms = sec_to_ms;
        CFG_BLOWER_ON: cfg_d.blow_on_ms = sec_to_ms;
        CFG_HUM_LOW:   cfg_d.hum_low    = wr_data_i[23:0];
        CFG_TEMP_HI_0: cfg_d.thr50_0    = thr50;
        CFG_TEMP_HI_1: cfg_d.thr50_1    = thr50;
        CFG_TEMP_HI_2: cfg_d.thr50_2    = thr50;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_sec <= IntervalRst;
      cfg_q.third_sec    <= ThirdRst;
      cfg_q.pump_on_ms   <= PumpMsRst;
      cfg_q.blow_on_ms   <= BlowMsRst;
      cfg_q.hum_low      <= HumLowRst;
      cfg_q.thr50_0      <= Thr50Rst;
      cfg_q.thr50_1      <= Thr50Rst;
      cfg_q.thr50_2      <= Thr50Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pbas_sched.sv =====
module pbas_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pbas_pkg::in_item_t  item_i,
  input  pbas_pkg::cfg_t      cfg_i,
  output pbas_pkg::out_item_t res_o
);
  import pbas_pkg::*;

  logic        pump_running_q, pump_running_d;
  logic [31:0] pump_start_ms_q, pump_start_ms_d;
  phase_e      phase_q, phase_d;
  logic [31:0] phase_start_ms_q, phase_start_ms_d;
  logic [31:0] last_pump_epoch_q, last_pump_epoch_d;
  logic [31:0] last_blower_epoch_q, last_blower_epoch_d;

  logic        dry, hot;
  logic [31:0] pump_gap, blower_gap, pump_elapsed, phase_elapsed;
  logic        pump_start, pump_on, pump_done;
  logic        sched_start, hot_start, blower_start;
  logic        one_done, two_done;
  logic signed [15:0] lhs_0, lhs_1, lhs_2;

  assign dry = ({1'b0, item_i.humidity_0} < cfg_i.hum_low[7:0])
            || ({1'b0, item_i.humidity_1} < cfg_i.hum_low[15:8])
            || ({1'b0, item_i.humidity_2} < cfg_i.hum_low[23:16]);

  // 9*t + 1600 >= 50*thr, exact Fahrenheit compare
  assign lhs_0 = {{4{item_i.temp_c10_0[11]}}, item_i.temp_c10_0} * 16'sd9 + 16'sd1600;
  assign lhs_1 = {{4{item_i.temp_c10_1[11]}}, item_i.temp_c10_1} * 16'sd9 + 16'sd1600;
  assign lhs_2 = {{4{item_i.temp_c10_2[11]}}, item_i.temp_c10_2} * 16'sd9 + 16'sd1600;
  assign hot = (lhs_0 >= cfg_i.thr50_0) || (lhs_1 >= cfg_i.thr50_1)
            || (lhs_2 >= cfg_i.thr50_2);

  assign pump_gap      = item_i.epoch_sec - last_pump_epoch_q;
  assign blower_gap    = item_i.epoch_sec - last_blower_epoch_q;
  assign pump_elapsed  = item_i.uptime_ms - pump_start_ms_q;
  assign phase_elapsed = item_i.uptime_ms - phase_start_ms_q;

  assign pump_start = !pump_running_q && (phase_q == PH_IDLE) && dry
                   && (pump_gap >= PumpRearmSec);
  // a fresh start has zero elapsed time
  assign pump_done  = pump_start ? (cfg_i.pump_on_ms == '0)
                                 : (pump_elapsed >= {6'd0, cfg_i.pump_on_ms});
  assign pump_on    = (pump_running_q || pump_start) && !pump_done;

  assign sched_start  = (phase_q == PH_IDLE) && !pump_on
                     && (blower_gap >= cfg_i.interval_sec);
  assign hot_start    = !sched_start && hot && !pump_on
                     && (blower_gap >= cfg_i.third_sec);
  assign blower_start = sched_start || hot_start;

  // phase one entered this tick sees zero elapsed time
  assign one_done = blower_start ? (cfg_i.blow_on_ms == '0)
                                 : (phase_elapsed >= {6'd0, cfg_i.blow_on_ms});
  assign two_done = (cfg_i.blow_on_ms == '0)
                 || (phase_elapsed >= {6'd0, cfg_i.blow_on_ms});

  always_comb begin
    pump_running_d      = pump_on;
    pump_start_ms_d     = pump_start ? item_i.uptime_ms : pump_start_ms_q;
    last_pump_epoch_d   = pump_start ? item_i.epoch_sec : last_pump_epoch_q;
    last_blower_epoch_d = blower_start ? item_i.epoch_sec : last_blower_epoch_q;
    phase_d             = phase_q;
    phase_start_ms_d    = phase_start_ms_q;
    if (blower_start || phase_q == PH_ONE) begin
      if (one_done) begin
        // a phase two entered now ends now only for a zero on-time
        phase_d          = (cfg_i.blow_on_ms == '0) ? PH_IDLE : PH_TWO;
        phase_start_ms_d = item_i.uptime_ms;
      end else begin
        phase_d          = PH_ONE;
        phase_start_ms_d = blower_start ? item_i.uptime_ms : phase_start_ms_q;
      end
    end else if (phase_q == PH_TWO && two_done) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_running_q      <= 1'b0;
      pump_start_ms_q     <= '0;
      phase_q             <= PH_IDLE;
      phase_start_ms_q    <= '0;
      last_pump_epoch_q   <= '0;
      last_blower_epoch_q <= '0;
    end else if (step_i) begin
      pump_running_q      <= pump_running_d;
      pump_start_ms_q     <= pump_start_ms_d;
      phase_q             <= phase_d;
      phase_start_ms_q    <= phase_start_ms_d;
      last_pump_epoch_q   <= last_pump_epoch_d;
      last_blower_epoch_q <= last_blower_epoch_d;
    end
  end

  always_comb begin
    res_o                = '0;
    res_o.pump_drive     = pump_running_d;
    res_o.blower1_drive  = (phase_d == PH_ONE);
    res_o.blower2_drive  = (phase_d == PH_TWO);
    res_o.pump_started   = pump_start;
    res_o.blower_started = blower_start;
    res_o.hot_start      = hot_start;
    unique case (phase_d)
      PH_IDLE: res_o.blower_phase = PhaseCodeIdle;
      PH_ONE:  res_o.blower_phase = PhaseCodeOne;
      PH_TWO:  res_o.blower_phase = PhaseCodeTwo;
      default: res_o.blower_phase = PhaseCodeIdle;
    endcase
  end

endmodule

// ===== design/pump_blower_actuator_scheduler_top.sv =====
// flow: a request is registered at the input, then evaluated and captured in
//   the result register once the result slot is empty or being drained; its
//   result is offered from the result register
// throughput: one request per cycle while results are taken, set by the state update loop
// reset: rst_ni asynchronous active low; clears all schedule state, both
//   pipeline valid flags and restores configuration defaults
module pump_blower_actuator_scheduler_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbas_in_if.sink    in_i,
  pbas_out_if.source out_o,
  pbas_cfg_if.sink   cfg_i
);
  import pbas_pkg::*;

  // input register
  logic      in_valid_q;
  in_item_t  in_q;
  // result register
  logic      out_valid_q;
  out_item_t out_q;

  logic      advance;
  logic      in_ready;
  out_item_t res;
  cfg_t      cfg;

  // an input request moves into the result register when the result slot
  // is empty or being drained this cycle
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  // the input register refills as it empties, so requests flow every cycle while results are taken
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  pbas_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.idx),
    .wr_data_i (cfg_i.wdata),
    .cfg_o     (cfg)
  );

  // schedule state advances exactly once per request that moves forward
  pbas_sched u_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= in_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // a hot start is always a blower start
  a_hot_is_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.hot_start || out_q.blower_started))
    else $error("hot start without blower start");

  // drives agree with the reported phase, which is never the unused code
  a_phase_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.blower_phase != PhaseCodeBad)
      && (out_q.blower1_drive == (out_q.blower_phase == PhaseCodeOne))
      && (out_q.blower2_drive == (out_q.blower_phase == PhaseCodeTwo)))
    else $error("blower drive does not match phase");

  // a held request is not lost or altered while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("pending request dropped");

  // a fresh result always lands when a request advances
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled");

endmodule

// ===== tb/sv/actuator_schedule_checker.sv =====
`timescale 1ns / 100ps

module actuator_schedule_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbas_in_if          tick_mon,
  pbas_out_if         act_mon,
  pbas_cfg_if         cfg_mon,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import pbas_pkg::*;

  localparam logic [15:0]       PumpOnRstSec   = 16'd10;
  localparam logic [15:0]       BlowerOnRstSec = 16'd60;
  localparam logic signed [9:0] TempHiRstF     = 10'sd140;

  // register copies
  logic [31:0]       interval_sec;
  logic [15:0]       pump_on_sec;
  logic [15:0]       blower_on_sec;
  logic [23:0]       hum_low;
  logic signed [9:0] temp_hi_f [3];

  // schedule state
  logic        pump_on;
  logic [31:0] pump_t0_ms;
  logic [1:0]  seq_phase;
  logic [31:0] phase_t0_ms;
  logic [31:0] last_pump_epoch;
  logic [31:0] last_blower_epoch;

  out_item_t   act_q[$];
  out_item_t   head;
  int unsigned n_err = 0;

  // advances the schedule by one tick and returns the expected actuator levels and start flags
  function automatic out_item_t schedule_tick(in_item_t t);
    logic [6:0]  hum [3];
    int          degc10 [3];
    logic [31:0] pump_ms;
    logic [31:0] blow_ms;
    logic [31:0] since_pump;
    logic [31:0] since_blower;
    logic        dry;
    logic        hot;
    logic        p_start;
    logic        b_start;
    logic        h_start;
    int          i;
    out_item_t   r;
    hum[0]    = t.humidity_0;
    hum[1]    = t.humidity_1;
    hum[2]    = t.humidity_2;
    degc10[0] = int'($signed(t.temp_c10_0));
    degc10[1] = int'($signed(t.temp_c10_1));
    degc10[2] = int'($signed(t.temp_c10_2));
    dry = 1'b0;
    hot = 1'b0;
    p_start = 1'b0;
    b_start = 1'b0;
    h_start = 1'b0;
    pump_ms = 32'(pump_on_sec) * 32'(MsPerSec);
    blow_ms = 32'(blower_on_sec) * 32'(MsPerSec);

    for (i = 0; i < 3; i++) begin
      if (8'(hum[i]) < hum_low[8*i +: 8]) dry = 1'b1;
    end

    since_pump = t.epoch_sec - last_pump_epoch;
    if (!pump_on && seq_phase == PhaseCodeIdle && dry && since_pump >= PumpRearmSec) begin
      pump_on         = 1'b1;
      pump_t0_ms      = t.uptime_ms;
      last_pump_epoch = t.epoch_sec;
      p_start         = 1'b1;
    end
    if (pump_on && 32'(t.uptime_ms - pump_t0_ms) >= pump_ms) pump_on = 1'b0;

    // exact fahrenheit test: t/10 * 9/5 + 32 >= thr
    for (i = 0; i < 3; i++) begin
      if (9 * degc10[i] + 1600 >= 50 * int'($signed(temp_hi_f[i]))) hot = 1'b1;
    end

    since_blower = t.epoch_sec - last_blower_epoch;
    if (seq_phase == PhaseCodeIdle && !pump_on && since_blower >= interval_sec) begin
      b_start = 1'b1;
    end else if (hot && !pump_on && since_blower >= interval_sec / 32'd3) begin
      b_start = 1'b1;
      h_start = 1'b1;
    end
    if (b_start) begin
      seq_phase         = PhaseCodeOne;
      phase_t0_ms       = t.uptime_ms;
      last_blower_epoch = t.epoch_sec;
    end

    if (seq_phase == PhaseCodeOne && 32'(t.uptime_ms - phase_t0_ms) >= blow_ms) begin
      seq_phase   = PhaseCodeTwo;
      phase_t0_ms = t.uptime_ms;
    end
    if (seq_phase == PhaseCodeTwo && 32'(t.uptime_ms - phase_t0_ms) >= blow_ms) begin
      seq_phase = PhaseCodeIdle;
    end

    r.pump_drive     = pump_on;
    r.blower1_drive  = (seq_phase == PhaseCodeOne);
    r.blower2_drive  = (seq_phase == PhaseCodeTwo);
    r.blower_phase   = seq_phase;
    r.pump_started   = p_start;
    r.blower_started = b_start;
    r.hot_start      = h_start;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_sec      = IntervalRst;
      pump_on_sec       = PumpOnRstSec;
      blower_on_sec     = BlowerOnRstSec;
      hum_low           = HumLowRst;
      temp_hi_f[0]      = TempHiRstF;
      temp_hi_f[1]      = TempHiRstF;
      temp_hi_f[2]      = TempHiRstF;
      pump_on           = 1'b0;
      pump_t0_ms        = '0;
      seq_phase         = PhaseCodeIdle;
      phase_t0_ms       = '0;
      last_pump_epoch   = '0;
      last_blower_epoch = '0;
      act_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.idx)
          CFG_INTERVAL:  interval_sec  = cfg_mon.wdata;
          CFG_PUMP_ON:   pump_on_sec   = cfg_mon.wdata[15:0];
          CFG_BLOWER_ON: blower_on_sec = cfg_mon.wdata[15:0];
          CFG_HUM_LOW:   hum_low       = cfg_mon.wdata[23:0];
          CFG_TEMP_HI_0: temp_hi_f[0]  = cfg_mon.wdata[9:0];
          CFG_TEMP_HI_1: temp_hi_f[1]  = cfg_mon.wdata[9:0];
          CFG_TEMP_HI_2: temp_hi_f[2]  = cfg_mon.wdata[9:0];
          default: ;
        endcase
      end
      // results first, so a stray one is never matched to a tick of this edge
      if (act_mon.valid && act_mon.ready) begin
        if (act_q.size() == 0) begin
          $error("actuator result with no tick outstanding");
          n_err++;
        end else begin
          head = act_q.pop_front();
          check_field("pump_drive", head.pump_drive, act_mon.item.pump_drive);
          check_field("blower1_drive", head.blower1_drive, act_mon.item.blower1_drive);
          check_field("blower2_drive", head.blower2_drive, act_mon.item.blower2_drive);
          check_field("blower_phase", head.blower_phase, act_mon.item.blower_phase);
          check_field("pump_started", head.pump_started, act_mon.item.pump_started);
          check_field("blower_started", head.blower_started, act_mon.item.blower_started);
          check_field("hot_start", head.hot_start, act_mon.item.hot_start);
        end
      end
      if (tick_mon.valid && tick_mon.ready) act_q.push_back(schedule_tick(tick_mon.item));
    end
    err_cnt_o <= n_err;
    pending_o <= act_q.size();
  end

endmodule

// ===== tb/sv/tb_pump_blower_actuator_scheduler_top.sv =====
`timescale 1ns / 100ps

module tb_pump_blower_actuator_scheduler_top;
  import pbas_pkg::*;

  // generous bound for about 750 requests
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseCnt      = 8;
  localparam int unsigned TicksPerPhase = 88;
  // slack left after every tick has its result
  localparam int unsigned DrainCycles   = 4;
  // index past the last register, must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic        clk;
  logic        rst_n;
  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned ready_hold = 0;
  bit          in_idle;
  bit          out_idle;
  logic [31:0] epoch_cur;
  logic [31:0] ms_cur;

  pbas_in_if  tick_if ();
  pbas_out_if act_if ();
  pbas_cfg_if cfg_if ();

  pump_blower_actuator_scheduler_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .out_o  (act_if),
    .cfg_i  (cfg_if)
  );

  // watches all three channels, predicts and compares
  actuator_schedule_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .tick_mon  (tick_if),
    .act_mon   (act_if),
    .cfg_mon   (cfg_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: with idling on, ready is dropped at random after each accepted result
  always @(posedge clk) begin
    if (act_if.valid === 1'b1 && act_if.ready === 1'b1 && out_idle) begin
      ready_hold = $urandom_range(0, 3);
    end
    if (ready_hold != 0) begin
      act_if.ready <= 1'b0;
      ready_hold--;
    end else begin
      act_if.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_pump_blower_actuator_scheduler_top: done, errors");
      $finish;
    end
  end

  function automatic in_item_t mk_tick(logic [31:0] epoch, logic [31:0] ms,
                                       int h0, int h1, int h2, int t0, int t1, int t2);
    in_item_t t;
    t.epoch_sec  = epoch;
    t.uptime_ms  = ms;
    t.humidity_0 = 7'(h0);
    t.humidity_1 = 7'(h1);
    t.humidity_2 = 7'(h2);
    t.temp_c10_0 = 12'(t0);
    t.temp_c10_1 = 12'(t1);
    t.temp_c10_2 = 12'(t2);
    return t;
  endfunction

  // cool readings, but hot_pct percent drawn over the whole sensor range
  function automatic int rand_temp(int unsigned hot_pct);
    if ($urandom_range(0, 99) < hot_pct) return int'($urandom_range(0, 1650)) - 400;
    return int'($urandom_range(0, 600)) - 400;
  endfunction

  function automatic logic [7:0] hum_thr();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 100));
  endfunction

  function automatic int temp_thr();
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 364)) - 64;
    return int'($urandom_range(100, 200));
  endfunction

  // one tick request, with a random gap in front when idling is on
  task automatic send_tick(in_item_t t);
    int unsigned gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.item  <= t;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
  endtask

  // valid stays up across a batch, the caller drops it at the end
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.wdata <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // all registers; bits above each register's width carry junk
  task automatic set_config(logic [31:0] interval, logic [15:0] pump_s, logic [15:0] blow_s,
                            logic [23:0] hum, int thr0, int thr1, int thr2);
    write_reg(CFG_INTERVAL, interval);
    write_reg(CFG_PUMP_ON, {16'($urandom), pump_s});
    write_reg(CFG_BLOWER_ON, {16'($urandom), blow_s});
    write_reg(CFG_HUM_LOW, {8'($urandom), hum});
    write_reg(CFG_TEMP_HI_0, {22'($urandom), 10'(thr0)});
    write_reg(CFG_TEMP_HI_1, {22'($urandom), 10'(thr1)});
    write_reg(CFG_TEMP_HI_2, {22'($urandom), 10'(thr2)});
    write_reg(CfgIdxSpare, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending and wait until every tick has its result
  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    int unsigned p;
    int unsigned dt;
    int unsigned step_max;
    int unsigned hot_pct;
    logic [31:0] ival;
    logic [15:0] pump_s;
    logic [15:0] blow_s;

    rst_n         <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.item  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.idx    <= CFG_INTERVAL;
    cfg_if.wdata  <= '0;
    in_idle  = 1'b1;
    out_idle = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset configuration: 3600 s interval, 140 F, no dry threshold
    // nothing due yet; coldest and driest readings
    send_tick(mk_tick(32'd0, 32'd0, 0, 0, 0, -400, -400, -400));
    // scheduled blower start, then phase two, then back to idle
    send_tick(mk_tick(32'd3600, 32'd1000, 100, 100, 100, 0, 0, 0));
    send_tick(mk_tick(32'd3610, 32'd61000, 50, 50, 50, 0, 0, 0));
    send_tick(mk_tick(32'd3620, 32'd121000, 50, 50, 50, 0, 0, 0));
    // exactly 140 F, one second short of a third of the interval
    send_tick(mk_tick(32'd4799, 32'd130000, 50, 50, 50, 600, 0, 0));
    // exactly 140 F at a third of the interval: over-temperature start
    send_tick(mk_tick(32'd4800, 32'd131000, 50, 50, 50, 600, 0, 0));
    // a tenth below the threshold on every sensor
    send_tick(mk_tick(32'd4801, 32'd132000, 50, 50, 50, 599, 599, 599));
    // hottest reading restarts the running sequence
    send_tick(mk_tick(32'd6000, 32'd140000, 50, 50, 50, 0, 0, 1250));
    settle();

    // zero on-times; only sensor 2 has a dry threshold
    set_config(32'd3600, 16'd0, 16'd0, 24'h64_00_00, 140, 140, 140);
    // pump starts and ends in one tick
    send_tick(mk_tick(32'hFFFF_F000, 32'h8000_0000, 0, 0, 99, 0, 0, 0));
    // top of both counters; a sequence runs through in one tick
    send_tick(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 100, 100, 1250, 1250, 1250));
    // wall clock wraps, pump rearm measured across it
    send_tick(mk_tick(32'h0000_0300, 32'h0000_0100, 100, 100, 0, 0, 0, 0));
    settle();

    // opposite extremes: longest on-times, zero interval, highest dry and lowest temperature thresholds
    set_config(32'd0, 16'hFFFF, 16'hFFFF, 24'hFF_FF_FF, -64, -64, -64);
    send_tick(mk_tick(32'h0000_1000, 32'hFFFF_FF00, 100, 100, 100, 0, 0, 0));
    // uptime wraps while the pump runs; hot but the pump blocks the blowers
    send_tick(mk_tick(32'h0000_1001, 32'h0000_0100, 100, 100, 100, -400, -400, -400));
    send_tick(mk_tick(32'h0000_1002, 32'h0000_0200, 50, 50, 50, 0, 0, 0));
    settle();

    // longest interval, 300 F never reached, zero thresholds never dry
    set_config(32'hFFFF_FFFF, 16'd1, 16'd60, 24'h00_00_00, 300, 300, 300);
    send_tick(mk_tick(32'h0000_1003, 32'h0000_0400, 0, 0, 0, 1250, 1250, 1250));
    send_tick(mk_tick(32'h0000_1004, 32'h0000_0800, 0, 0, 0, 1250, 1250, 1250));
    settle();

    // short times so restarts land in both phases
    set_config(32'd3, 16'd2, 16'd1, 24'h50_50_50, 140, 140, 140);
    send_tick(mk_tick(32'h0000_2000, 32'h0000_1000, 10, 90, 90, 0, 0, 0));
    send_tick(mk_tick(32'h0000_2001, 32'h0000_17D0, 90, 90, 90, 700, 0, 0));
    send_tick(mk_tick(32'h0000_2002, 32'h0000_19C4, 90, 90, 90, 0, 700, 0));
    send_tick(mk_tick(32'h0000_2003, 32'h0000_1DAC, 90, 90, 90, 0, 0, 0));
    send_tick(mk_tick(32'h0000_2004, 32'h0000_1ED8, 90, 90, 90, 0, 0, 700));

    // --- random: one configuration per phase, time moving forward in steps
    for (p = 0; p < PhaseCnt; p++) begin
      settle();
      // first phase runs with no idling on either side
      in_idle  = (p % 3) != 0;
      out_idle = (p % 4) != 0;

      case ($urandom_range(0, 7))
        0:       ival = '0;
        1:       ival = '1;
        2:       ival = $urandom;
        default: ival = $urandom_range(30, 1200);
      endcase
      pump_s = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
      blow_s = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
      set_config(ival, pump_s, blow_s, {hum_thr(), hum_thr(), hum_thr()},
                 temp_thr(), temp_thr(), temp_thr());

      hot_pct = $urandom_range(0, 40);
      case ($urandom_range(0, 3))
        0:       step_max = 1;
        1:       step_max = 10;
        2:       step_max = 60;
        default: step_max = 400;
      endcase
      // start points near the wrap of either counter now and then
      epoch_cur = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                              : $urandom;
      ms_cur    = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                              : $urandom;

      repeat (TicksPerPhase) begin
        if ($urandom_range(0, 15) == 0) begin
          // glitch: arbitrary clocks, the time base is left where it was
          send_tick(mk_tick($urandom, $urandom, $urandom_range(0, 100),
                            $urandom_range(0, 100), $urandom_range(0, 100),
                            rand_temp(100), rand_temp(100), rand_temp(100)));
        end else begin
          dt = $urandom_range(0, step_max);
          epoch_cur = epoch_cur + dt;
          ms_cur    = ms_cur + 32'(dt * 1000) + 32'($urandom_range(0, 999));
          send_tick(mk_tick(epoch_cur, ms_cur, $urandom_range(0, 100),
                            $urandom_range(0, 100), $urandom_range(0, 100),
                            rand_temp(hot_pct), rand_temp(hot_pct), rand_temp(hot_pct)));
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb_pump_blower_actuator_scheduler_top: done, clean");
    end else begin
      $display("tb_pump_blower_actuator_scheduler_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pbas_pkg.sv
design/pbas_if.sv
design/pbas_cfg_regs.sv
design/pbas_sched.sv
design/pump_blower_actuator_scheduler_top.sv
tb/sv/actuator_schedule_checker.sv
tb/sv/tb_pump_blower_actuator_scheduler_top.sv
